// ===== rtl/hpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_pkg: shared types for the homogeneous polygon clipper
// Beat payload structs and the internal vertex word layout.
// ----------------------------------------------------------------------------
package hpc_pkg;

    localparam int NUM_ATTR = 10;
    localparam int NUM_POS  = 4;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_w;
        logic [15:0]        col_r;
        logic [15:0]        col_g;
        logic [15:0]        col_b;
        logic [15:0]        col_a;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
    } in_vtx_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic [15:0]        out_r;
        logic [15:0]        out_g;
        logic [15:0]        out_b;
        logic [15:0]        out_a;
        logic [15:0]        out_u;
        logic [15:0]        out_v;
        logic               last_vertex;
        logic               rejected;
    } out_vtx_t;

    // attribute view: 0..3 position, 4..9 color and texture (zero extended)
    typedef logic [NUM_ATTR-1:0][31:0] vattr_t;

    localparam int VTX_W = $bits(in_vtx_t);

    function automatic vattr_t to_attr(input in_vtx_t v);
        vattr_t a;
        a[0] = v.pos_x;
        a[1] = v.pos_y;
        a[2] = v.pos_z;
        a[3] = v.pos_w;
        a[4] = {16'h0, v.col_r};
        a[5] = {16'h0, v.col_g};
        a[6] = {16'h0, v.col_b};
        a[7] = {16'h0, v.col_a};
        a[8] = {16'h0, v.tex_u};
        a[9] = {16'h0, v.tex_v};
        return a;
    endfunction

    function automatic in_vtx_t from_attr(input vattr_t a);
        in_vtx_t v;
        v.pos_x = a[0];
        v.pos_y = a[1];
        v.pos_z = a[2];
        v.pos_w = a[3];
        v.col_r = a[4][15:0];
        v.col_g = a[5][15:0];
        v.col_b = a[6][15:0];
        v.col_a = a[7][15:0];
        v.tex_u = a[8][15:0];
        v.tex_v = a[9][15:0];
        return v;
    endfunction

endpackage

// ===== rtl/hpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hpc_ram #(
    parameter int WIDTH = 224,
    parameter int DEPTH = 18
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/hpc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_div: radix-2 restoring divider for the crossing fraction
// q = round(num * 2^FRAC / den), num <= den, den > 0; one bit per cycle.
// ----------------------------------------------------------------------------
module hpc_div #(
    parameter int FRAC = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [33:0]     num,
    input  logic [33:0]     den,
    output logic            busy,
    output logic [FRAC:0]   q
);
    localparam int NW = 35 + FRAC;
    localparam int CNT_W = $clog2(FRAC + 2);

    logic [NW-1:0]    dvd;
    logic [34:0]      rem_reg, rem_next;
    logic [FRAC:0]    low_reg, low_next;
    logic [FRAC:0]    q_reg, q_next;
    logic [33:0]      den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [34:0]      trial;

    assign dvd   = NW'({num, FRAC'(0)}) + NW'(den >> 1);
    assign trial = {rem_reg[33:0], low_reg[FRAC]};

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            // quotient fits FRAC+1 bits, so the top part is already below den
            rem_next  = 35'(dvd[NW-1:FRAC+1]);
            low_next  = dvd[FRAC:0];
            den_next  = den;
            q_next    = '0;
            cnt_next  = CNT_W'(FRAC + 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[FRAC-1:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[FRAC-1:0], 1'b0};
            end
            low_next = {low_reg[FRAC-1:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign q    = q_reg;
endmodule

// ===== rtl/homogeneous_polygon_clipper_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_polygon_clipper_top: clip-space triangle frustum clipper
// Collects three vertices, clips against the six w-planes one after the
// other (Sutherland-Hodgman) and streams out the surviving polygon.
// ----------------------------------------------------------------------------
//
//  channel | ports                     | beat
//  --------+---------------------------+---------------------------------
//  input   | s_valid s_ready s_data    | one clip-space vertex
//  output  | m_valid m_ready m_data    | one polygon vertex, or a reject
//
//  The first two vertices of a triangle are only stored. The third starts six
//  plane passes; each pass loads the closing vertex, then reads each vertex in
//  turn, compares both plane sides and keeps it, and a crossing adds a divider
//  run, ten serial multiplies and the store of the new vertex.
//  Output reads each vertex from the RAM and holds it until m_ready; s_ready
//  stays low from the third vertex until the last beat is taken.
//  aresetn (synchronous) clears the sequencer, counts and valid flag only;
//  the vertex RAM holds no reset value and is always written before read.
//
module homogeneous_polygon_clipper_top #(
    parameter int MAX_POLY_VERTICES = 9,
    parameter int POS_FRAC_BITS     = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hpc_pkg::in_vtx_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output hpc_pkg::out_vtx_t  m_data
);
    import hpc_pkg::*;

    localparam int MAXV  = MAX_POLY_VERTICES;
    localparam int FRAC  = POS_FRAC_BITS;
    localparam int DEPTH = 2 * MAXV;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAXV + 1);
    localparam int PW    = 36 + FRAC;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PASS  = 4'd1;
    localparam logic [3:0] S_LPREV = 4'd2;
    localparam logic [3:0] S_RCUR  = 4'd3;
    localparam logic [3:0] S_LCUR  = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_WMID  = 4'd8;
    localparam logic [3:0] S_KEEP  = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_ORD   = 4'd11;
    localparam logic [3:0] S_OLD   = 4'd12;
    localparam logic [3:0] S_OWAIT = 4'd13;

    localparam logic [2:0] LAST_PASS = 3'd5;
    localparam logic [3:0] ATTR_END  = 4'(NUM_ATTR);
    localparam logic [CW-1:0] MAXV_C = CW'(MAXV);

    logic [3:0]     state_reg, state_next;
    logic [2:0]     pass_reg, pass_next;
    logic [1:0]     loaded_reg, loaded_next;
    logic [CW-1:0]  cnt0_reg, cnt0_next, cnt1_reg, cnt1_next;
    logic [CW-1:0]  n_reg, n_next, idx_reg, idx_next, m_reg, m_next;
    logic [3:0]     k_reg, k_next;
    vattr_t         prev_reg, prev_next, cur_reg, cur_next, mid_reg, mid_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    out_vtx_t       out_reg, out_next;
    logic           m_valid_reg, m_valid_next;

    // RAM side
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [VTX_W-1:0] ram_wdata, ram_rdata;

    // divider side
    logic           div_start, div_busy;
    logic [FRAC:0]  div_q;
    logic [33:0]    div_num, div_den;

    logic           src, neg;
    logic [1:0]     axis;
    logic [AW-1:0]  base_src, base_dst;
    logic signed [32:0] dprev, dcur;
    logic           in_prev, in_cur;
    vattr_t         rd_attr;
    logic signed [33:0] diff;
    logic signed [PW-1:0] rnd;
    logic [31:0]    lerp_val;

    function automatic logic signed [33:0] attr_s(input vattr_t v, input logic [3:0] k);
        if (k < 4'(NUM_POS)) begin
            return {{2{v[k][31]}}, v[k]};
        end
        return {18'h0, v[k][15:0]};
    endfunction

    // signed distance inside the plane: w - (+/-)component
    function automatic logic signed [32:0] plane_dist(input vattr_t v, input logic [1:0] ax,
                                                      input logic ng);
        logic signed [32:0] c;
        logic signed [32:0] w;
        c = {v[{2'b00, ax}][31], v[{2'b00, ax}]};
        w = {v[3][31], v[3]};
        return ng ? w + c : w - c;
    endfunction

    assign src      = pass_reg[0];
    assign neg      = pass_reg[0];
    assign axis     = pass_reg[2:1];
    assign base_src = src ? AW'(MAXV) : '0;
    assign base_dst = src ? '0 : AW'(MAXV);
    assign dprev    = plane_dist(prev_reg, axis, neg);
    assign dcur     = plane_dist(cur_reg, axis, neg);
    assign in_prev  = !dprev[32];
    assign in_cur   = !dcur[32];
    assign rd_attr  = to_attr(in_vtx_t'(ram_rdata));

    assign div_num = dprev[32] ? 34'(-{dprev[32], dprev}) : 34'({1'b0, dprev});
    assign div_den = div_num + (dcur[32] ? 34'(-{dcur[32], dcur}) : 34'({1'b0, dcur}));

    assign diff     = attr_s(cur_reg, k_reg) - attr_s(prev_reg, k_reg);
    assign rnd      = (prod_reg + (PW'(1) <<< (FRAC - 1))) >>> FRAC;
    assign lerp_val = prev_reg[k_reg - 4'd1] + rnd[31:0];

    always_comb begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        loaded_next  = loaded_reg;
        cnt0_next    = cnt0_reg;
        cnt1_next    = cnt1_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        m_next       = m_reg;
        k_next       = k_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        mid_next     = mid_reg;
        prod_next    = prod_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = s_data;
        ram_raddr    = base_src + AW'(idx_reg);
        div_start    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(loaded_reg);
                    if (loaded_reg == 2'd2) begin
                        loaded_next = '0;
                        cnt0_next   = CW'(3);
                        pass_next   = '0;
                        state_next  = S_PASS;
                    end else begin
                        loaded_next = loaded_reg + 2'd1;
                    end
                end
            end
            S_PASS: begin
                n_next    = src ? cnt1_reg : cnt0_reg;
                ram_raddr = base_src + AW'(n_next) - AW'(1);
                idx_next  = '0;
                m_next    = '0;
                if (n_next == '0) begin
                    if (src) cnt0_next = '0;
                    else     cnt1_next = '0;
                    state_next = S_NEXT;
                end else begin
                    state_next = S_LPREV;
                end
            end
            S_LPREV: begin
                prev_next  = rd_attr;
                state_next = S_RCUR;
            end
            S_RCUR: begin
                state_next = S_LCUR;
            end
            S_LCUR: begin
                cur_next   = rd_attr;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if ((in_cur != in_prev) && (m_reg < MAXV_C)) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end else begin
                    state_next = S_KEEP;
                end
            end
            S_DIV: begin
                k_next = '0;
                if (!div_busy) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                // multiply for attribute k, finish attribute k-1 behind it
                if (k_reg < ATTR_END) begin
                    prod_next = diff * $signed({1'b0, div_q});
                end
                if (k_reg != '0) begin
                    mid_next[k_reg - 4'd1] = lerp_val;
                end
                if (k_reg == ATTR_END) begin
                    state_next = S_WMID;
                end
                k_next = k_reg + 4'd1;
            end
            S_WMID: begin
                ram_we     = 1'b1;
                ram_waddr  = base_dst + AW'(m_reg);
                ram_wdata  = from_attr(mid_reg);
                m_next     = m_reg + 1'b1;
                state_next = S_KEEP;
            end
            S_KEEP: begin
                if (in_cur && (m_reg < MAXV_C)) begin
                    ram_we    = 1'b1;
                    ram_waddr = base_dst + AW'(m_reg);
                    ram_wdata = from_attr(cur_reg);
                    m_next    = m_reg + 1'b1;
                end
                prev_next = cur_reg;
                if (idx_reg + 1'b1 == n_reg) begin
                    if (src) cnt0_next = m_next;
                    else     cnt1_next = m_next;
                    state_next = S_NEXT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RCUR;
                end
            end
            S_NEXT: begin
                idx_next = '0;
                if (pass_reg == LAST_PASS) begin
                    if (cnt0_reg == '0) begin
                        out_next             = '0;
                        out_next.last_vertex = 1'b1;
                        out_next.rejected    = 1'b1;
                        m_valid_next         = 1'b1;
                        state_next           = S_OWAIT;
                    end else begin
                        state_next = S_ORD;
                    end
                end else begin
                    pass_next  = pass_reg + 3'd1;
                    state_next = S_PASS;
                end
            end
            S_ORD: begin
                ram_raddr  = AW'(idx_reg);
                state_next = S_OLD;
            end
            S_OLD: begin
                out_next.out_x       = rd_attr[0];
                out_next.out_y       = rd_attr[1];
                out_next.out_z       = rd_attr[2];
                out_next.out_w       = rd_attr[3];
                out_next.out_r       = rd_attr[4][15:0];
                out_next.out_g       = rd_attr[5][15:0];
                out_next.out_b       = rd_attr[6][15:0];
                out_next.out_a       = rd_attr[7][15:0];
                out_next.out_u       = rd_attr[8][15:0];
                out_next.out_v       = rd_attr[9][15:0];
                out_next.last_vertex = (idx_reg + 1'b1 == cnt0_reg);
                out_next.rejected    = 1'b0;
                m_valid_next         = 1'b1;
                state_next           = S_OWAIT;
            end
            S_OWAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (out_reg.last_vertex) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pass_reg    <= '0;
            loaded_reg  <= '0;
            cnt0_reg    <= '0;
            cnt1_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            loaded_reg  <= loaded_next;
            cnt0_reg    <= cnt0_next;
            cnt1_reg    <= cnt1_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        m_reg    <= m_next;
        k_reg    <= k_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        mid_reg  <= mid_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    hpc_ram #(
        .WIDTH (VTX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hpc_div #(
        .FRAC (FRAC)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .q       (div_q)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
endmodule

// ===== rtl/hpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_checker: port-level checks for the polygon clipper
// Watches the top-level handshakes; attached by bind.
// ----------------------------------------------------------------------------
module hpc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input hpc_pkg::out_vtx_t m_data
);
    import hpc_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rejected |-> m_data.last_vertex && m_data.out_x == 0
            && m_data.out_w == 0 && m_data.out_r == 0)
        else $error("reject beat not a clean final beat");

    a_more: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_vertex |=> !s_ready)
        else $error("clipper went idle in the middle of a polygon");
endmodule

bind homogeneous_polygon_clipper_top hpc_checker u_hpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
